[rtl/h264fua_pkg.sv]
// Shared types and constants for the H.264 AVCC to RTP FU-A packetiser.
`timescale 1ns / 1ps

package h264fua_pkg;

  localparam int NAL_LENGTH_BITS_DEF = 32;

  localparam logic [2:0]  PLEN_RESET    = 3'd4;
  localparam logic [15:0] MAX_PKT_RESET = 16'd1200;
  localparam logic [6:0]  PTYPE_RESET   = 7'd96;

  localparam logic [1:0] REG_PLEN   = 2'd0;
  localparam logic [1:0] REG_MAXPKT = 2'd1;
  localparam logic [1:0] REG_PTYPE  = 2'd2;

  localparam logic [2:0]  PLEN_ONE  = 3'd1;
  localparam logic [2:0]  PLEN_TWO  = 3'd2;
  localparam logic [2:0]  PLEN_FOUR = 3'd4;
  localparam logic [15:0] MIN_PKT   = 16'd3;
  localparam logic [15:0] FU_OVERHEAD = 16'd2;
  localparam logic [4:0]  FUA_TYPE  = 5'd28;
  localparam logic [31:0] TS_SCALE  = 32'd90;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       st;
    logic       en;
    logic       mk;
    logic       tr;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       seq_inc;
  } step_ctl_t;

endpackage

[rtl/h264fua_step.sv]
// Per-byte parse and packetisation logic: next state and up to three payload bytes.
`timescale 1ns / 1ps

module h264fua_step import h264fua_pkg::*; #(
  parameter int LB = NAL_LENGTH_BITS_DEF
) (
  input  phase_t          phase,
  input  logic [2:0]      prefix_count,
  input  logic [LB-1:0]   nal_rem,
  input  logic [15:0]     fill,
  input  logic            frag,
  input  logic [7:0]      hdr,
  input  logic [2:0]      plen_cfg,
  input  logic [15:0]     max_pkt,
  input  logic [7:0]      b,
  input  logic            eof,
  output phase_t          phase_next,
  output logic [2:0]      prefix_count_next,
  output logic [LB-1:0]   nal_rem_next,
  output logic [15:0]     fill_next,
  output logic            frag_next,
  output logic [7:0]      hdr_next,
  output item_t           items [3],
  output step_ctl_t       ctl
);

  localparam int CW = (LB > 16) ? LB : 16;

  logic [15:0]   eff_max;
  logic [15:0]   cap;
  logic [2:0]    plen;
  logic [2:0]    cnt1;
  logic [LB-1:0] base;
  logic [LB+7:0] shifted;
  logic [LB-1:0] acc;
  logic [LB-1:0] rem1;
  logic          need_hdr;
  logic [15:0]   fill0;
  logic [15:0]   fill1;
  logic          en;
  logic [7:0]    indicator;

  assign eff_max = (max_pkt < MIN_PKT) ? MIN_PKT : max_pkt;
  assign cap     = eff_max - FU_OVERHEAD;
  assign cnt1    = prefix_count + 3'd1;
  assign base    = (prefix_count == 3'd0) ? '0 : nal_rem;
  assign shifted = {base, b};
  assign acc     = shifted[LB-1:0];
  assign rem1    = nal_rem - LB'(1);

  always_comb begin
    case (plen_cfg)
      PLEN_ONE: plen = PLEN_ONE;
      PLEN_TWO: plen = PLEN_TWO;
      default:  plen = PLEN_FOUR;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    prefix_count_next = prefix_count;
    nal_rem_next      = nal_rem;
    fill_next         = fill;
    frag_next         = frag;
    hdr_next          = hdr;
    for (int i = 0; i < 3; i++) items[i] = '0;
    ctl       = '0;
    need_hdr  = 1'b0;
    fill0     = fill;
    fill1     = 16'd0;
    en        = 1'b0;
    indicator = 8'd0;

    case (phase)
      PH_HEADER: begin
        hdr_next = b;
        if (!frag) begin
          en = (rem1 == '0) || eof;
          items[0] = '{data: b, st: 1'b1, en: en, mk: eof, tr: eof && (rem1 != '0)};
          ctl.count = 2'd1;
          if (en) begin
            ctl.seq_inc       = 1'b1;
            phase_next        = PH_PREFIX;
            prefix_count_next = 3'd0;
            nal_rem_next      = '0;
            fill_next         = 16'd0;
            frag_next         = 1'b0;
          end else begin
            phase_next   = PH_BODY;
            nal_rem_next = rem1;
          end
        end else begin
          indicator = {b[7:5], FUA_TYPE};
          items[0] = '{data: indicator, st: 1'b1, en: 1'b0, mk: 1'b0, tr: 1'b0};
          items[1] = '{data: {3'b100, b[4:0]}, st: 1'b0, en: eof, mk: eof, tr: eof};
          ctl.count = 2'd2;
          if (eof) begin
            ctl.seq_inc       = 1'b1;
            phase_next        = PH_PREFIX;
            prefix_count_next = 3'd0;
            nal_rem_next      = '0;
            fill_next         = 16'd0;
            frag_next         = 1'b0;
          end else begin
            fill_next    = 16'd0;
            phase_next   = PH_BODY;
            nal_rem_next = rem1;
          end
        end
      end
      PH_BODY: begin
        need_hdr = frag && (fill >= cap);
        if (need_hdr) begin
          indicator = {hdr[7:5], FUA_TYPE};
          items[0] = '{data: indicator, st: 1'b1, en: 1'b0, mk: 1'b0, tr: 1'b0};
          items[1] = '{data: {1'b0, CW'(nal_rem) <= CW'(cap), hdr[5:0] & 6'h1f},
                       st: 1'b0, en: 1'b0, mk: 1'b0, tr: 1'b0};
          fill0 = 16'd0;
        end
        fill1 = fill0 + 16'd1;
        en = (rem1 == '0) || eof || (frag && (fill1 >= cap));
        items[need_hdr ? 2 : 0] = '{data: b, st: 1'b0, en: en, mk: eof,
                                    tr: eof && (rem1 != '0)};
        ctl.count   = need_hdr ? 2'd3 : 2'd1;
        ctl.seq_inc = en;
        if ((rem1 == '0) || eof) begin
          phase_next        = PH_PREFIX;
          prefix_count_next = 3'd0;
          nal_rem_next      = '0;
          fill_next         = 16'd0;
          frag_next         = 1'b0;
        end else begin
          nal_rem_next = rem1;
          fill_next    = fill1;
        end
      end
      default: begin
        phase_next = PH_PREFIX;
        if (cnt1 >= plen) begin
          prefix_count_next = 3'd0;
          if ((acc == '0) || eof) begin
            nal_rem_next = '0;
            fill_next    = 16'd0;
            frag_next    = 1'b0;
          end else begin
            phase_next   = PH_HEADER;
            nal_rem_next = acc;
            frag_next    = CW'(acc) >= CW'(eff_max);
          end
        end else if (eof) begin
          prefix_count_next = 3'd0;
          nal_rem_next      = '0;
          fill_next         = 16'd0;
          frag_next         = 1'b0;
        end else begin
          prefix_count_next = cnt1;
          nal_rem_next      = acc;
        end
      end
    endcase
  end

endmodule

[rtl/h264fua_outq.sv]
// Result buffer: holds the up to three payload bytes of one input byte and drains one a cycle while out_ready is high.
`timescale 1ns / 1ps

module h264fua_outq import h264fua_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  item_t       items [3],
  input  logic [1:0]  load_count,
  input  logic [15:0] load_seq,
  input  logic [31:0] load_ts,
  input  logic        out_ready,
  output logic        can_load,
  output logic        out_valid,
  output item_t       head_item,
  output logic [15:0] seq,
  output logic [31:0] ts
);

  item_t      slots [3];
  logic [1:0] head;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign head_item = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 2'd0;
    end else if (load) begin
      head  <= 2'd0;
      count <= load_count;
    end else if (pop) begin
      head  <= head + 2'd1;
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) slots[i] <= items[i];
      seq <= load_seq;
      ts  <= load_ts;
    end
  end

endmodule

[rtl/h264_avcc_rtp_fua_packetizer.sv]
// Top level of the H.264 AVCC to RTP single-NAL / FU-A packetiser.
`timescale 1ns / 1ps

// Takes one frame byte per transaction and emits RTP payload bytes one per cycle
// while out_ready is high. Length prefix bytes produce nothing; a NAL byte that
// is carried unchanged gives one output byte. The first byte of a fragmented NAL
// gives two output bytes (indicator, FU header) and a byte that opens a new
// fragment gives three, so input is held off while the three-entry result buffer
// drains one byte per cycle. With out_ready high the sustained rate is one byte
// per cycle outside those points. Configuration writes are always accepted and
// should be made only while no transaction is in flight.
module h264_avcc_rtp_fua_packetizer import h264fua_pkg::*; #(
  parameter int NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_frame,
  input  logic [31:0] frame_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_start,
  output logic        packet_end,
  output logic        rtp_marker,
  output logic [15:0] sequence_number,
  output logic [31:0] rtp_timestamp,
  output logic [6:0]  rtp_payload_type,
  output logic        truncated_nal
);

  localparam int LB = NAL_LENGTH_BITS;

  logic [2:0]  length_prefix_bytes;
  logic [15:0] max_packet_size;
  logic [6:0]  payload_type;

  phase_t        parse_phase, parse_phase_next;
  logic [2:0]    prefix_count, prefix_count_next;
  logic [LB-1:0] nal_remaining, nal_remaining_next;
  logic [15:0]   fragment_fill, fragment_fill_next;
  logic          fragmenting, fragmenting_next;
  logic [7:0]    nal_header_byte, nal_header_byte_next;
  logic [15:0]   next_sequence;

  item_t       items [3];
  step_ctl_t   ctl;
  item_t       head_item;
  logic        accept;
  logic [31:0] ts_scaled;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign ts_scaled = frame_time_ms * TS_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_prefix_bytes <= PLEN_RESET;
      max_packet_size     <= MAX_PKT_RESET;
      payload_type        <= PTYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLEN:   length_prefix_bytes <= cfg_data[2:0];
        REG_MAXPKT: max_packet_size     <= cfg_data;
        REG_PTYPE:  payload_type        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  h264fua_step #(.LB(LB)) u_step (
    .phase             (parse_phase),
    .prefix_count      (prefix_count),
    .nal_rem           (nal_remaining),
    .fill              (fragment_fill),
    .frag              (fragmenting),
    .hdr               (nal_header_byte),
    .plen_cfg          (length_prefix_bytes),
    .max_pkt           (max_packet_size),
    .b                 (in_byte),
    .eof               (end_of_frame),
    .phase_next        (parse_phase_next),
    .prefix_count_next (prefix_count_next),
    .nal_rem_next      (nal_remaining_next),
    .fill_next         (fragment_fill_next),
    .frag_next         (fragmenting_next),
    .hdr_next          (nal_header_byte_next),
    .items             (items),
    .ctl               (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_PREFIX;
      prefix_count    <= 3'd0;
      nal_remaining   <= '0;
      fragment_fill   <= 16'd0;
      fragmenting     <= 1'b0;
      nal_header_byte <= 8'd0;
      next_sequence   <= 16'd0;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      prefix_count    <= prefix_count_next;
      nal_remaining   <= nal_remaining_next;
      fragment_fill   <= fragment_fill_next;
      fragmenting     <= fragmenting_next;
      nal_header_byte <= nal_header_byte_next;
      if (ctl.seq_inc) next_sequence <= next_sequence + 16'd1;
    end
  end

  h264fua_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .items      (items),
    .load_count (ctl.count),
    .load_seq   (next_sequence),
    .load_ts    (ts_scaled),
    .out_ready  (out_ready),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .head_item  (head_item),
    .seq        (sequence_number),
    .ts         (rtp_timestamp)
  );

  assign out_byte         = head_item.data;
  assign packet_start     = head_item.st;
  assign packet_end       = head_item.en;
  assign rtp_marker       = head_item.en && head_item.mk;
  assign truncated_nal    = head_item.en && head_item.tr;
  assign rtp_payload_type = payload_type;

  a_marker_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rtp_marker) |-> packet_end)
    else $error("marker outside packet end");

  a_trunc_marks_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated_nal) |-> rtp_marker)
    else $error("truncated NAL without marker");

  a_seq_within_packet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !packet_end) |=>
      (!out_valid || ($stable(sequence_number) && !packet_start)))
    else $error("sequence number changed inside a packet");

endmodule

[tb/tb.sv]
// Testbench for the H.264 AVCC to RTP FU-A packetiser: predicts and checks every payload byte.
`timescale 1ns / 1ps

module tb;
  import h264fua_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] NRI_MASK  = 8'hE0;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_START  = 8'h80;
  localparam logic [7:0] FU_END    = 8'h40;
  localparam int HOLD_OFF   = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 10;

  typedef struct packed {
    logic [7:0]  b;
    logic        eof;
    logic [31:0] ms;
  } avcc_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        st;
    logic        en;
    logic        mk;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [6:0]  pt;
    logic        tr;
  } rtp_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_PLEN;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        end_of_frame = 1'b0;
  logic [31:0] frame_time_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        packet_start;
  logic        packet_end;
  logic        rtp_marker;
  logic [15:0] sequence_number;
  logic [31:0] rtp_timestamp;
  logic [6:0]  rtp_payload_type;
  logic        truncated_nal;

  h264_avcc_rtp_fua_packetizer dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .end_of_frame(end_of_frame), .frame_time_ms(frame_time_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .packet_start(packet_start), .packet_end(packet_end), .rtp_marker(rtp_marker),
    .sequence_number(sequence_number), .rtp_timestamp(rtp_timestamp),
    .rtp_payload_type(rtp_payload_type), .truncated_nal(truncated_nal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  avcc_byte_t avcc_q[$];
  rtp_byte_t  rtp_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int packets = 0;
  int cut_short = 0;
  int settings = 0;
  int quiet_cycles = 0;

  // packetiser state as the block should hold it
  logic [2:0]  cfg_plen = PLEN_RESET;
  logic [15:0] cfg_maxpkt = MAX_PKT_RESET;
  logic [6:0]  cfg_ptype = PTYPE_RESET;
  phase_t      nal_phase = PH_PREFIX;
  logic [2:0]  pfx_count = '0;
  logic [31:0] nal_left = '0;
  logic [15:0] frag_fill = '0;
  logic        fua_mode = 1'b0;
  logic [7:0]  hdr_byte = '0;
  logic [15:0] seq_next = '0;

  function automatic void restart_nal();
    nal_phase = PH_PREFIX;
    pfx_count = '0;
    nal_left = '0;
    frag_fill = '0;
    fua_mode = 1'b0;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic st, logic en, logic mk, logic tr,
                                      logic [31:0] ts);
    rtp_byte_t r;
    r.data = b;
    r.st = st;
    r.en = en;
    r.mk = en & mk;
    r.seq = seq_next;
    r.ts = ts;
    r.pt = cfg_ptype;
    r.tr = en & tr;
    rtp_due.insert(rtp_due.size(), r);
  endfunction

  function automatic void packetize(logic [7:0] b, logic eof, logic [31:0] ms);
    logic [31:0] ts;
    logic [15:0] lim;
    logic [15:0] cap;
    logic [2:0]  need;
    logic        last;
    ts = ms * TS_SCALE;
    lim = (cfg_maxpkt < MIN_PKT) ? MIN_PKT : cfg_maxpkt;
    cap = lim - FU_OVERHEAD;
    need = (cfg_plen == PLEN_ONE) ? 3'd1 : (cfg_plen == PLEN_TWO) ? 3'd2 : 3'd4;
    case (nal_phase)
      PH_HEADER: begin
        hdr_byte = b;
        nal_left = nal_left - 32'd1;
        if (!fua_mode) begin
          last = (nal_left == 0) || eof;
          expect_byte(b, 1'b1, last, eof, eof && nal_left != 0, ts);
          if (last) begin
            seq_next = seq_next + 16'd1;
            restart_nal();
          end else begin
            nal_phase = PH_BODY;
          end
        end else begin
          expect_byte((b & NRI_MASK) + 8'(FUA_TYPE), 1'b1, 1'b0, 1'b0, 1'b0, ts);
          expect_byte((b & TYPE_MASK) | FU_START, 1'b0, eof, eof, eof, ts);
          if (eof) begin
            seq_next = seq_next + 16'd1;
            restart_nal();
          end else begin
            frag_fill = '0;
            nal_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (fua_mode && frag_fill >= cap) begin
          expect_byte((hdr_byte & NRI_MASK) + 8'(FUA_TYPE), 1'b1, 1'b0, 1'b0, 1'b0, ts);
          expect_byte((hdr_byte & TYPE_MASK) | ((nal_left <= cap) ? FU_END : 8'h00),
                      1'b0, 1'b0, 1'b0, 1'b0, ts);
          frag_fill = '0;
        end
        frag_fill = frag_fill + 16'd1;
        nal_left = nal_left - 32'd1;
        last = (nal_left == 0) || eof || (fua_mode && frag_fill >= cap);
        expect_byte(b, 1'b0, last, eof, eof && nal_left != 0, ts);
        if (last) seq_next = seq_next + 16'd1;
        if (nal_left == 0 || eof) restart_nal();
      end
      default: begin
        nal_phase = PH_PREFIX;
        if (pfx_count == 0) nal_left = '0;
        nal_left = {nal_left[23:0], b};
        pfx_count = pfx_count + 3'd1;
        if (pfx_count >= need) begin
          pfx_count = '0;
          if (nal_left == 0 || eof) begin
            restart_nal();
          end else begin
            nal_phase = PH_HEADER;
            fua_mode = nal_left >= lim;
          end
        end else if (eof) begin
          restart_nal();
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch on %s: got %0h, want %0h (output byte %0d)", what, got, want, bytes_out);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PLEN:   cfg_plen = val[2:0];
      REG_MAXPKT: cfg_maxpkt = val;
      REG_PTYPE:  cfg_ptype = val[6:0];
      default: ;
    endcase
  endtask

  task automatic enqueue_frame(input logic [31:0] ms, input logic [7:0] fb[$]);
    avcc_byte_t it;
    for (int i = 0; i < fb.size(); i++) begin
      it.b = fb[i];
      it.eof = (i == fb.size() - 1);
      it.ms = ms;
      avcc_q.insert(avcc_q.size(), it);
    end
  endtask

  task automatic push_hex_frame(input logic [31:0] ms, input int n, input logic [127:0] bits);
    logic [7:0] fb[$];
    for (int i = n - 1; i >= 0; i--) fb.insert(fb.size(), bits[8*i +: 8]);
    enqueue_frame(ms, fb);
  endtask

  // mostly well-formed frames; some noise and some cut short at a random byte
  task automatic queue_random_frame();
    logic [7:0] fb[$];
    int plen;
    int lim;
    int len;
    int lo;
    int hi;
    int cut;
    plen = (cfg_plen == PLEN_ONE) ? 1 : (cfg_plen == PLEN_TWO) ? 2 : 4;
    lim = (cfg_maxpkt < MIN_PKT) ? int'(MIN_PKT) : int'(cfg_maxpkt);
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(6, 1)) fb.insert(fb.size(), 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(9))
          0: len = 0;
          1, 2, 3: len = $urandom_range((lim - 1 < 40) ? lim - 1 : 40, 1);
          default: begin
            lo = (lim < 40) ? lim : 40;
            hi = (lim + 9 < 48) ? lim + 9 : 48;
            len = $urandom_range(hi, lo);
          end
        endcase
        for (int i = plen - 1; i >= 0; i--) fb.insert(fb.size(), 8'(len >> (8 * i)));
        repeat (len) fb.insert(fb.size(), 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(4) == 0 && fb.size() > 1) begin
      cut = $urandom_range(fb.size() - 1, 1);
      while (fb.size() > cut) fb.delete(fb.size() - 1);
    end
    enqueue_frame($urandom(), fb);
  endtask

  task automatic settle();
    do @(posedge clk); while (avcc_q.size() != 0 || in_valid || rtp_due.size() != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    avcc_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        packetize(in_byte, end_of_frame, frame_time_ms);
        bytes_in++;
      end
      if (!in_valid || in_ready) begin
        if (avcc_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = avcc_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.b;
          end_of_frame <= nxt.eof;
          frame_time_ms <= nxt.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    rtp_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_out++;
      if (packet_end) packets++;
      if (packet_end && truncated_nal) cut_short++;
      if (rtp_due.size() == 0) begin
        report_mismatch("out_byte with nothing pending", out_byte, '0);
      end else begin
        want = rtp_due.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (packet_start !== want.st) report_mismatch("packet_start", packet_start, want.st);
        if (packet_end !== want.en) report_mismatch("packet_end", packet_end, want.en);
        if (rtp_marker !== want.mk) report_mismatch("rtp_marker", rtp_marker, want.mk);
        if (sequence_number !== want.seq)
          report_mismatch("sequence_number", sequence_number, want.seq);
        if (rtp_timestamp !== want.ts) report_mismatch("rtp_timestamp", rtp_timestamp, want.ts);
        if (rtp_payload_type !== want.pt)
          report_mismatch("rtp_payload_type", rtp_payload_type, want.pt);
        if (truncated_nal !== want.tr) report_mismatch("truncated_nal", truncated_nal, want.tr);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [2:0]  plen;
    logic [15:0] maxpkt;
    logic [6:0]  ptype;
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2-byte prefixes, 4-byte packets so FU-A kicks in early
    write_reg(REG_PLEN, {13'($urandom), PLEN_TWO});
    write_reg(REG_MAXPKT, 16'd4);
    write_reg(REG_PTYPE, {9'($urandom), 7'd127});
    cfg_valid <= 1'b0;
    settings++;
    // empty NAL, single NAL, fragmented NAL ending with the frame
    push_hex_frame(32'hFFFF_FFFF, 13, 104'h00000002FF8000057C11223344);
    // frame ends inside a prefix
    push_hex_frame(32'h0, 1, 8'h00);
    // frame ends on the last prefix byte
    push_hex_frame(32'h1234_5678, 2, 16'h0003);
    // cut short on the header: single packet, then FU-A
    push_hex_frame(32'h0BAD_F00D, 3, 24'h000341);
    push_hex_frame(32'h4000_0001, 3, 24'h00093C);
    // cut short in the first fragment body
    push_hex_frame(32'h8765_4321, 4, 32'h00091FAA);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      ptype = 7'($urandom);
      case (p)
        0: begin plen = PLEN_ONE;  maxpkt = MIN_PKT;   ptype = '0;     end
        1: begin plen = PLEN_TWO;  maxpkt = 16'd0;     ptype = 7'd127; end
        2: begin plen = PLEN_FOUR; maxpkt = 16'hFFFF;  end
        3: begin plen = 3'd7;      maxpkt = MAX_PKT_RESET; end
        4: begin plen = PLEN_ONE;  maxpkt = 16'd2;     end
        5: begin plen = 3'd0;      maxpkt = 16'd5;     end
        6: begin plen = 3'd3;      maxpkt = 16'd1;     end
        default: begin plen = PLEN_TWO; maxpkt = 16'($urandom_range(30, 3)); end
      endcase
      write_reg(REG_PLEN, {13'($urandom), plen});
      write_reg(REG_MAXPKT, maxpkt);
      write_reg(REG_PTYPE, {9'($urandom), ptype});
      if (p == 4) write_reg(REG_SPARE, 16'($urandom));
      cfg_valid <= 1'b0;
      settings++;
      target = avcc_q.size() + PHASE_BYTES;
      while (avcc_q.size() < target) queue_random_frame();
      settle();
    end

    $display("Sent %0d frame bytes across %0d register settings and four idling patterns.",
             bytes_in, settings);
    $display("Checked %0d payload bytes in %0d packets, %0d of them cut short by frame end.",
             bytes_out, packets, cut_short);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[h264_avcc_rtp_fua_packetizer.f]
rtl/h264fua_pkg.sv
rtl/h264fua_step.sv
rtl/h264fua_outq.sv
rtl/h264_avcc_rtp_fua_packetizer.sv
tb/tb.sv
